// ----- hdl/qvr_pkg.sv -----
package qvr_pkg;

	localparam int COMPONENT_WIDTH = 16;
	localparam int PROD_W = 2 * COMPONENT_WIDTH;
	localparam int T_W = 2 * COMPONENT_WIDTH + 2;
	localparam int PROD2_W = T_W + COMPONENT_WIDTH;
	localparam int ACC_W = PROD2_W + 2;
	localparam int ROUND_SHIFT = 2 * (COMPONENT_WIDTH - 1);

	typedef logic signed [COMPONENT_WIDTH-1:0] comp_t;

	typedef struct packed {
		comp_t quat_w;
		comp_t quat_x;
		comp_t quat_y;
		comp_t quat_z;
		comp_t vec_x;
		comp_t vec_y;
		comp_t vec_z;
	} qvr_in_t;

	typedef struct packed {
		comp_t rot_x;
		comp_t rot_y;
		comp_t rot_z;
		logic  saturated;
	} qvr_out_t;

	typedef struct packed {
		comp_t w;
		comp_t x;
		comp_t y;
		comp_t z;
	} qvr_quat_t;

endpackage

// ----- hdl/qvr_round_sat.sv -----
module qvr_round_sat (
	input  logic signed [qvr_pkg::ACC_W-1:0] acc,
	output qvr_pkg::comp_t                   val,
	output logic                             clip
);

	localparam int AW = qvr_pkg::ACC_W;
	localparam int SH = qvr_pkg::ROUND_SHIFT;
	localparam int CW = qvr_pkg::COMPONENT_WIDTH;
	localparam int HW = AW - SH;
	localparam logic [AW-1:0] HALF = {{(AW - SH){1'b0}}, 1'b1, {(SH - 1){1'b0}}};

	logic signed [AW-1:0] sum;
	logic        [HW-1:0] high;
	logic                 sign;
	logic                 fits;

	always_comb begin
		sum  = acc + $signed(HALF);
		high = sum[AW-1:SH];
		sign = high[HW-1];
		fits = (high[HW-1:CW-1] == {(HW - CW + 1){sign}});
		clip = !fits;
		if (fits) begin
			val = high[CW-1:0];
		end else if (sign) begin
			val = {1'b1, {(CW - 1){1'b0}}};
		end else begin
			val = {1'b0, {(CW - 1){1'b1}}};
		end
	end

endmodule

// ----- hdl/quaternion_vector_rotate.sv -----
// Rotates a vector by a quaternion: the result is the vector part of
// q * (0, v) * conj(q), scaled by 2^-30, rounded to nearest and saturated.
// The input channel (vec_valid, vec_stall, vec_word) takes one word holding
// the quaternion and the vector; the output channel (rot_valid, rot_stall,
// rot_word) returns one word with the rotated vector and a saturation flag.
// The datapath is five register stages: the first products, the first sums,
// the second products, the second sums, and rounding with saturation.
// A word moves through the stages in that order and is registered in each; one
// word can be accepted in every cycle while vec_stall is low.
// Each stage moves forward when the stage after it is empty or moving, so
// empty slots close up while the receiver stalls, and an input word is still
// taken until all five stages hold data. A stalled output word holds steady.
// Reset clears all valid bits; the block then takes a word in the first cycle.
// A quaternion that is not of unit length scales the vector by its squared norm.
module quaternion_vector_rotate (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             vec_valid,
	output logic             vec_stall,
	input  qvr_pkg::qvr_in_t vec_word,
	output logic             rot_valid,
	input  logic             rot_stall,
	output qvr_pkg::qvr_out_t rot_word
);

	localparam int PW = qvr_pkg::PROD_W;
	localparam int TW = qvr_pkg::T_W;
	localparam int P2W = qvr_pkg::PROD2_W;
	localparam int AW = qvr_pkg::ACC_W;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic rdy1, rdy2, rdy3, rdy4, rdy5;

	qvr_pkg::qvr_quat_t q_s1, q_s2;

	logic signed [PW-1:0] xx_s1, yy_s1, zz_s1;
	logic signed [PW-1:0] wx_s1, yz_s1, zy_s1;
	logic signed [PW-1:0] wy_s1, xz_s1, zx_s1;
	logic signed [PW-1:0] wz_s1, xy_s1, yx_s1;

	logic signed [TW-1:0] tw_s2, tx_s2, ty_s2, tz_s2;

	logic signed [P2W-1:0] xw_s3, wxq_s3, yzq_s3, zyq_s3;
	logic signed [P2W-1:0] yw_s3, wyq_s3, xzq_s3, zxq_s3;
	logic signed [P2W-1:0] zw_s3, wzq_s3, xyq_s3, yxq_s3;

	logic signed [AW-1:0] rx_s4, ry_s4, rz_s4;

	qvr_pkg::comp_t rx_val, ry_val, rz_val;
	logic           rx_clip, ry_clip, rz_clip;

	qvr_pkg::qvr_out_t out_s5;

	assign rdy5 = !v_s5 || !rot_stall;
	assign rdy4 = !v_s4 || rdy5;
	assign rdy3 = !v_s3 || rdy4;
	assign rdy2 = !v_s2 || rdy3;
	assign rdy1 = !v_s1 || rdy2;

	assign vec_stall = !rdy1;
	assign rot_valid = v_s5;
	assign rot_word  = out_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (rdy1) begin
				v_s1 <= vec_valid;
			end
			if (rdy2) begin
				v_s2 <= v_s1;
			end
			if (rdy3) begin
				v_s3 <= v_s2;
			end
			if (rdy4) begin
				v_s4 <= v_s3;
			end
			if (rdy5) begin
				v_s5 <= v_s4;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (rdy1) begin
			q_s1.w <= vec_word.quat_w;
			q_s1.x <= vec_word.quat_x;
			q_s1.y <= vec_word.quat_y;
			q_s1.z <= vec_word.quat_z;
			xx_s1  <= vec_word.quat_x * vec_word.vec_x;
			yy_s1  <= vec_word.quat_y * vec_word.vec_y;
			zz_s1  <= vec_word.quat_z * vec_word.vec_z;
			wx_s1  <= vec_word.quat_w * vec_word.vec_x;
			yz_s1  <= vec_word.quat_y * vec_word.vec_z;
			zy_s1  <= vec_word.quat_z * vec_word.vec_y;
			wy_s1  <= vec_word.quat_w * vec_word.vec_y;
			xz_s1  <= vec_word.quat_x * vec_word.vec_z;
			zx_s1  <= vec_word.quat_z * vec_word.vec_x;
			wz_s1  <= vec_word.quat_w * vec_word.vec_z;
			xy_s1  <= vec_word.quat_x * vec_word.vec_y;
			yx_s1  <= vec_word.quat_y * vec_word.vec_x;
		end
		if (rdy2) begin
			q_s2  <= q_s1;
			tw_s2 <= -(TW'(xx_s1) + TW'(yy_s1) + TW'(zz_s1));
			tx_s2 <= TW'(wx_s1) + TW'(yz_s1) - TW'(zy_s1);
			ty_s2 <= TW'(wy_s1) - TW'(xz_s1) + TW'(zx_s1);
			tz_s2 <= TW'(wz_s1) + TW'(xy_s1) - TW'(yx_s1);
		end
		if (rdy3) begin
			xw_s3  <= tx_s2 * q_s2.w;
			wxq_s3 <= tw_s2 * q_s2.x;
			yzq_s3 <= ty_s2 * q_s2.z;
			zyq_s3 <= tz_s2 * q_s2.y;
			yw_s3  <= ty_s2 * q_s2.w;
			wyq_s3 <= tw_s2 * q_s2.y;
			xzq_s3 <= tx_s2 * q_s2.z;
			zxq_s3 <= tz_s2 * q_s2.x;
			zw_s3  <= tz_s2 * q_s2.w;
			wzq_s3 <= tw_s2 * q_s2.z;
			xyq_s3 <= tx_s2 * q_s2.y;
			yxq_s3 <= ty_s2 * q_s2.x;
		end
		if (rdy4) begin
			rx_s4 <= AW'(xw_s3) - AW'(wxq_s3) - AW'(yzq_s3) + AW'(zyq_s3);
			ry_s4 <= AW'(yw_s3) - AW'(wyq_s3) + AW'(xzq_s3) - AW'(zxq_s3);
			rz_s4 <= AW'(zw_s3) - AW'(wzq_s3) - AW'(xyq_s3) + AW'(yxq_s3);
		end
		if (rdy5) begin
			out_s5.rot_x     <= rx_val;
			out_s5.rot_y     <= ry_val;
			out_s5.rot_z     <= rz_val;
			out_s5.saturated <= rx_clip || ry_clip || rz_clip;
		end
	end

	qvr_round_sat u_round_x (
		.acc  (rx_s4),
		.val  (rx_val),
		.clip (rx_clip)
	);

	qvr_round_sat u_round_y (
		.acc  (ry_s4),
		.val  (ry_val),
		.clip (ry_clip)
	);

	qvr_round_sat u_round_z (
		.acc  (rz_s4),
		.val  (rz_val),
		.clip (rz_clip)
	);

endmodule
